/* hdl/mf3_pkg.sv */
// ---------------------------------------------------------------------------
// mf3_pkg
// Shared constants, types and the compare-exchange schedule of the 3x3
// median filter.
// ---------------------------------------------------------------------------
package mf3_pkg;

  localparam int unsigned MaxLineBytes = 6144;
  localparam int unsigned MaxRows      = 4096;

  localparam int unsigned AddrW  = $clog2(MaxLineBytes);
  localparam int unsigned PixW   = 12;
  localparam int unsigned RowW   = 12;
  localparam int unsigned ColW   = 13;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned LsW    = 2 * ByteW;
  localparam int unsigned WinLen = 9;
  localparam int unsigned Taps   = 9;
  localparam int unsigned CxSteps = 19;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoLvlW  = $clog2(FifoDepth + 1);

  localparam logic [PixW-1:0] LinePixelsRst = PixW'(640);
  localparam logic [PixW-1:0] MinPixels     = PixW'(3);
  localparam logic [PixW-1:0] MaxPixels3    = PixW'(MaxLineBytes / 3);
  localparam logic [RowW-1:0] RowLimit      = RowW'(MaxRows - 1);

  typedef enum logic {
    RegLinePixels   = 1'b0,
    RegThreeChannel = 1'b1
  } reg_idx_e;

  typedef logic [3:0] tap_t;

  localparam tap_t CxLo [CxSteps] = '{
    4'd1, 4'd4, 4'd7, 4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd0,
    4'd5, 4'd4, 4'd3, 4'd1, 4'd2, 4'd4, 4'd4, 4'd6, 4'd4
  };
  localparam tap_t CxHi [CxSteps] = '{
    4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8, 4'd3,
    4'd8, 4'd7, 4'd6, 4'd4, 4'd5, 4'd7, 4'd2, 4'd4, 4'd2
  };

  typedef struct packed {
    logic [ByteW-1:0] median;
    logic [RowW-1:0]  center_row;
    logic [ColW-1:0]  center_column;
    logic             row_last;
  } result_t;

endpackage

/* hdl/median_3x3_window_filter.sv */
// ---------------------------------------------------------------------------
// median_3x3_window_filter
// 3x3 median filter over a raster byte stream of one gray channel or three
// interleaved channels, with a two-row line store and a same-channel window.
//
//   Channel   Handshake                    Payload
//   input     in_valid_i / in_ready_o      pixel_byte_i, frame_start_i
//   output    out_valid_o / out_ready_i    median_o, center_row_o,
//                                          center_column_o, row_last_o
//   config    psel, penable, pwrite        paddr, pwdata, prdata
//
// One input beat is taken per cycle. A result passes through the line
// store read register, the window stage and the result queue before it
// leaves. Reset clears the counters, the pipeline valids, the queue and
// the registers; the line store holds no reset value. When the output
// stalls, input beats are taken while the four-entry result queue
// still has room for every beat in flight.
// ---------------------------------------------------------------------------
module median_3x3_window_filter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [mf3_pkg::ByteW-1:0]   pixel_byte_i,
  input  logic                        frame_start_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [mf3_pkg::ByteW-1:0]   median_o,
  output logic [mf3_pkg::RowW-1:0]    center_row_o,
  output logic [mf3_pkg::ColW-1:0]    center_column_o,
  output logic                        row_last_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [mf3_pkg::PixW-1:0] line_pixels_q;
  logic                     three_ch_q;
  mf3_pkg::reg_idx_e        reg_sel;
  logic                     cfg_wr;

  logic [mf3_pkg::PixW-1:0] px_clamp;
  logic [mf3_pkg::ColW-1:0] rb;
  logic [mf3_pkg::ColW-1:0] ch;
  logic [mf3_pkg::ColW-1:0] ch2;

  logic [mf3_pkg::RowW-1:0] row_q, row_d;
  logic [mf3_pkg::ColW-1:0] col_q, col_d;
  logic [mf3_pkg::RowW-1:0] r0, r;
  logic [mf3_pkg::ColW-1:0] c0, c, c_next;
  logic                     emit;
  logic                     accept;

  logic                          v1_q, v2_q;
  logic                          emit1_q, emit2_q;
  logic [mf3_pkg::ByteW-1:0]     px1_q;
  logic [mf3_pkg::AddrW-1:0]     addr1_q;
  mf3_pkg::result_t              meta0, meta1_q, meta2_q;
  logic [mf3_pkg::LsW-1:0]       ls_rd;
  logic [mf3_pkg::ByteW-1:0]     win_q [3][mf3_pkg::WinLen];
  logic [mf3_pkg::ByteW-1:0]     taps [mf3_pkg::Taps];
  logic [mf3_pkg::ByteW-1:0]     med;
  mf3_pkg::result_t              push_data;
  mf3_pkg::result_t              out_data;
  logic [mf3_pkg::FifoLvlW-1:0]  level;
  logic [mf3_pkg::FifoLvlW-1:0]  occupied;

  // Configuration port.
  assign pready  = 1'b1;
  assign reg_sel = mf3_pkg::reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    unique case (reg_sel)
      mf3_pkg::RegLinePixels:   prdata = {20'd0, line_pixels_q};
      mf3_pkg::RegThreeChannel: prdata = {31'd0, three_ch_q};
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_pixels_q <= mf3_pkg::LinePixelsRst;
      three_ch_q    <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        mf3_pkg::RegLinePixels:   line_pixels_q <= pwdata[mf3_pkg::PixW-1:0];
        mf3_pkg::RegThreeChannel: three_ch_q    <= pwdata[0];
        default:                  line_pixels_q <= line_pixels_q;
      endcase
    end
  end

  // Row length in bytes and channel spacing.
  always_comb begin
    px_clamp = line_pixels_q;
    if (line_pixels_q < mf3_pkg::MinPixels) begin
      px_clamp = mf3_pkg::MinPixels;
    end else if (three_ch_q && (line_pixels_q > mf3_pkg::MaxPixels3)) begin
      px_clamp = mf3_pkg::MaxPixels3;
    end
    if (three_ch_q) begin
      rb  = {1'b0, px_clamp} + {px_clamp, 1'b0};
      ch  = mf3_pkg::ColW'(3);
      ch2 = mf3_pkg::ColW'(6);
    end else begin
      rb  = {1'b0, px_clamp};
      ch  = mf3_pkg::ColW'(1);
      ch2 = mf3_pkg::ColW'(2);
    end
  end

  // Position of the incoming beat and the counters after it.
  assign occupied   = level + mf3_pkg::FifoLvlW'(v1_q) + mf3_pkg::FifoLvlW'(v2_q);
  assign in_ready_o = occupied < mf3_pkg::FifoLvlW'(mf3_pkg::FifoDepth);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    r0 = frame_start_i ? '0 : row_q;
    c0 = frame_start_i ? '0 : col_q;
    if (c0 >= rb) begin
      c = '0;
      r = (r0 < mf3_pkg::RowLimit) ? r0 + mf3_pkg::RowW'(1) : r0;
    end else begin
      c = c0;
      r = r0;
    end
    c_next = c + mf3_pkg::ColW'(1);
    if (c_next >= rb) begin
      col_d = '0;
      row_d = (r < mf3_pkg::RowLimit) ? r + mf3_pkg::RowW'(1) : r;
    end else begin
      col_d = c_next;
      row_d = r;
    end
    emit                = (r >= mf3_pkg::RowW'(2)) && (c >= ch2);
    meta0.median        = '0;
    meta0.center_row    = r - mf3_pkg::RowW'(1);
    meta0.center_column = c - ch;
    meta0.row_last      = (c == rb - mf3_pkg::ColW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
    end else begin
      if (accept) begin
        row_q <= row_d;
        col_q <= col_d;
      end
      v1_q <= accept;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px1_q   <= pixel_byte_i;
      addr1_q <= c[mf3_pkg::AddrW-1:0];
      emit1_q <= emit;
      meta1_q <= meta0;
    end
    if (v1_q) begin
      emit2_q <= emit1_q;
      meta2_q <= meta1_q;
    end
  end

  mf3_line_store u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (c[mf3_pkg::AddrW-1:0]),
    .rd_data_o (ls_rd),
    .wr_en_i   (v1_q),
    .wr_addr_i (addr1_q),
    .wr_data_i ({ls_rd[mf3_pkg::ByteW-1:0], px1_q})
  );

  // Window of the three rows; row 0 is the oldest.
  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      for (int k = mf3_pkg::WinLen - 1; k > 0; k--) begin
        for (int w = 0; w < 3; w++) begin
          win_q[w][k] <= win_q[w][k-1];
        end
      end
      win_q[0][0] <= ls_rd[mf3_pkg::LsW-1:mf3_pkg::ByteW];
      win_q[1][0] <= ls_rd[mf3_pkg::ByteW-1:0];
      win_q[2][0] <= px1_q;
    end
  end

  always_comb begin
    for (int w = 0; w < 3; w++) begin
      taps[w*3+0] = three_ch_q ? win_q[w][6] : win_q[w][2];
      taps[w*3+1] = three_ch_q ? win_q[w][3] : win_q[w][1];
      taps[w*3+2] = win_q[w][0];
    end
  end

  mf3_median9 u_median9 (
    .p_i      (taps),
    .median_o (med)
  );

  always_comb begin
    push_data        = meta2_q;
    push_data.median = med;
  end

  mf3_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (v2_q && emit2_q),
    .push_data_i (push_data),
    .valid_o     (out_valid_o),
    .ready_i     (out_ready_i),
    .data_o      (out_data),
    .level_o     (level)
  );

  assign median_o        = out_data.median;
  assign center_row_o    = out_data.center_row;
  assign center_column_o = out_data.center_column;
  assign row_last_o      = out_data.row_last;

endmodule

/* hdl/mf3_line_store.sv */
// ---------------------------------------------------------------------------
// mf3_line_store
// Line memory holding the two rows above the current one, one 16-bit entry
// per byte column, with a registered read and write-to-read forwarding.
// ---------------------------------------------------------------------------
module mf3_line_store (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [mf3_pkg::AddrW-1:0] rd_addr_i,
  output logic [mf3_pkg::LsW-1:0]   rd_data_o,
  input  logic                     wr_en_i,
  input  logic [mf3_pkg::AddrW-1:0] wr_addr_i,
  input  logic [mf3_pkg::LsW-1:0]   wr_data_i
);

  logic [mf3_pkg::LsW-1:0] mem [mf3_pkg::MaxLineBytes];
  logic [mf3_pkg::LsW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_q <= wr_data_i;
      end else begin
        rd_q <= mem[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_q;

endmodule

/* hdl/mf3_median9.sv */
// ---------------------------------------------------------------------------
// mf3_median9
// Nineteen-step compare-exchange network that picks the median of nine
// bytes.
// ---------------------------------------------------------------------------
module mf3_median9 (
  input  logic [mf3_pkg::ByteW-1:0] p_i [mf3_pkg::Taps],
  output logic [mf3_pkg::ByteW-1:0] median_o
);

  logic [mf3_pkg::ByteW-1:0] net [mf3_pkg::Taps];
  logic [mf3_pkg::ByteW-1:0] lo_v;
  logic [mf3_pkg::ByteW-1:0] hi_v;

  always_comb begin
    for (int i = 0; i < mf3_pkg::Taps; i++) begin
      net[i] = p_i[i];
    end
    lo_v = '0;
    hi_v = '0;
    for (int k = 0; k < mf3_pkg::CxSteps; k++) begin
      lo_v = net[mf3_pkg::CxLo[k]];
      hi_v = net[mf3_pkg::CxHi[k]];
      if (lo_v > hi_v) begin
        net[mf3_pkg::CxLo[k]] = hi_v;
        net[mf3_pkg::CxHi[k]] = lo_v;
      end
    end
  end

  assign median_o = net[4];

endmodule

/* hdl/mf3_out_fifo.sv */
// ---------------------------------------------------------------------------
// mf3_out_fifo
// Four-entry result queue between the filter pipeline and the output
// channel.
// ---------------------------------------------------------------------------
module mf3_out_fifo (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  mf3_pkg::result_t             push_data_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output mf3_pkg::result_t             data_o,
  output logic [mf3_pkg::FifoLvlW-1:0] level_o
);

  mf3_pkg::result_t              mem_q [mf3_pkg::FifoDepth];
  logic [mf3_pkg::FifoPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [mf3_pkg::FifoPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [mf3_pkg::FifoLvlW-1:0]  level_q, level_d;
  logic                          pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (level_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign level_o = level_q;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + mf3_pkg::FifoPtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + mf3_pkg::FifoPtrW'(1) : rd_ptr_q;
    level_d  = level_q;
    if (push_i && !pop) begin
      level_d = level_q + mf3_pkg::FifoLvlW'(1);
    end else if (pop && !push_i) begin
      level_d = level_q - mf3_pkg::FifoLvlW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

endmodule
